[design/pcns_pkg.sv]
// Shared types, constants and the PLL settings ROM for the coefficient search.
package pcns_pkg;

    localparam int ROM_SIZE      = 43;
    localparam int TABLE_ENTRIES = 43;
    // number of leading ROM rows searched, kept within what the ROM holds
    localparam int SEARCH_COUNT  = (TABLE_ENTRIES < 1) ? 1 :
                                   (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE : TABLE_ENTRIES;
    localparam int IDX_W         = 6;
    localparam int F10K_W        = 14;
    localparam int HZ_W          = 32;
    localparam int ACT_W         = 28;
    localparam int HZ_PER_UNIT   = 10000;

    // floor(x / 10000) for 32-bit x == (x * DIV_MAGIC) >> DIV_SHIFT
    localparam logic [31:0] DIV_MAGIC = 32'hD1B7_1759;
    localparam int DIV_SHIFT     = 45;
    localparam int QUOT_W        = 2 * HZ_W - DIV_SHIFT;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEARCH_COUNT - 1);

    typedef struct packed {
        logic [F10K_W-1:0] f10k;
        logic [5:0]        m;
        logic [7:0]        n;
        logic [1:0]        k;
    } t_pll_row;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic [IDX_W-1:0] idx;
        logic             exact;
    } t_search_stat;

    function automatic t_pll_row pll_rom_row(input logic [IDX_W-1:0] idx);
        t_pll_row r;
        unique case (idx)
            6'd0:    r = '{14'd1431,  6'd8,  8'd72,  2'd1};
            6'd1:    r = '{14'd2506,  6'd2,  8'd27,  2'd1};
            6'd2:    r = '{14'd2520,  6'd23, 8'd168, 2'd1};
            6'd3:    r = '{14'd2595,  6'd6,  8'd50,  2'd1};
            6'd4:    r = '{14'd2744,  6'd7,  8'd61,  2'd1};
            6'd5:    r = '{14'd2828,  6'd8,  8'd71,  2'd1};
            6'd6:    r = '{14'd2833,  6'd21, 8'd174, 2'd1};
            6'd7:    r = '{14'd2864,  6'd2,  8'd24,  2'd2};
            6'd8:    r = '{14'd3007,  6'd3,  8'd34,  2'd2};
            6'd9:    r = '{14'd3150,  6'd8,  8'd80,  2'd2};
            6'd10:   r = '{14'd3257,  6'd8,  8'd83,  2'd2};
            6'd11:   r = '{14'd3375,  6'd5,  8'd58,  2'd2};
            6'd12:   r = '{14'd3589,  6'd3,  8'd17,  2'd1};
            6'd13:   r = '{14'd3759,  6'd6,  8'd34,  2'd1};
            6'd14:   r = '{14'd3848,  6'd6,  8'd35,  2'd1};
            6'd15:   r = '{14'd4009,  6'd8,  8'd48,  2'd1};
            6'd16:   r = '{14'd4398,  6'd5,  8'd35,  2'd1};
            6'd17:   r = '{14'd4474,  6'd6,  8'd42,  2'd1};
            6'd18:   r = '{14'd4725,  6'd3,  8'd25,  2'd1};
            6'd19:   r = '{14'd5011,  6'd3,  8'd27,  2'd1};
            6'd20:   r = '{14'd5190,  6'd6,  8'd50,  2'd1};
            6'd21:   r = '{14'd5489,  6'd7,  8'd61,  2'd1};
            6'd22:   r = '{14'd5656,  6'd8,  8'd71,  2'd1};
            6'd23:   r = '{14'd5727,  6'd2,  8'd24,  2'd1};
            6'd24:   r = '{14'd6014,  6'd3,  8'd34,  2'd2};
            6'd25:   r = '{14'd6300,  6'd8,  8'd80,  2'd1};
            6'd26:   r = '{14'd6515,  6'd8,  8'd83,  2'd1};
            6'd27:   r = '{14'd6750,  6'd5,  8'd58,  2'd1};
            6'd28:   r = '{14'd7159,  6'd3,  8'd17,  2'd0};
            6'd29:   r = '{14'd7517,  6'd6,  8'd34,  2'd0};
            6'd30:   r = '{14'd7696,  6'd6,  8'd35,  2'd0};
            6'd31:   r = '{14'd8018,  6'd8,  8'd48,  2'd0};
            6'd32:   r = '{14'd8795,  6'd5,  8'd35,  2'd0};
            6'd33:   r = '{14'd8949,  6'd6,  8'd42,  2'd0};
            6'd34:   r = '{14'd9450,  6'd3,  8'd25,  2'd0};
            6'd35:   r = '{14'd10023, 6'd4,  8'd34,  2'd0};
            6'd36:   r = '{14'd10500, 6'd7,  8'd58,  2'd0};
            6'd37:   r = '{14'd10818, 6'd7,  8'd60,  2'd0};
            6'd38:   r = '{14'd10977, 6'd7,  8'd61,  2'd0};
            6'd39:   r = '{14'd11812, 6'd2,  8'd25,  2'd0};
            6'd40:   r = '{14'd12027, 6'd3,  8'd34,  2'd0};
            6'd41:   r = '{14'd13091, 6'd5,  8'd56,  2'd0};
            6'd42:   r = '{14'd13500, 6'd7,  8'd58,  2'd0};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[design/pcns_if.sv]
// Valid/ready channel interfaces for the request and result beats.
interface pcns_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] target_hz;

    modport source (output valid, output target_hz, input ready);
    modport sink   (input valid, input target_hz, output ready);
endinterface

interface pcns_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  entry_index;
    logic [27:0] actual_hz;
    logic [5:0]  mult_m;
    logic [7:0]  div_n;
    logic [1:0]  post_k;
    logic [7:0]  data_low;
    logic [7:0]  data_high;
    logic        exact_match;

    modport source (output valid, output entry_index, output actual_hz, output mult_m,
                    output div_n, output post_k, output data_low, output data_high,
                    output exact_match, input ready);
    modport sink   (input valid, input entry_index, input actual_hz, input mult_m,
                    input div_n, input post_k, input data_low, input data_high,
                    input exact_match, output ready);
endinterface

[design/pcns_div.sv]
// Divide-by-10000 of the request via reciprocal multiply, two register stages.
module pcns_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [31:0]               i_target_hz,
    output logic                      o_quot_valid,
    output logic [pcns_pkg::QUOT_W-1:0] o_quot
);
    import pcns_pkg::*;

    logic [HZ_W-1:0]   r_x;
    logic              r_v1;
    logic              r_v2;
    logic [QUOT_W-1:0] r_q;
    logic [2*HZ_W-1:0] prod;

    assign prod = 64'(r_x) * 64'(DIV_MAGIC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_load;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_target_hz;
        end
        if (r_v1) begin
            r_q <= prod[DIV_SHIFT +: QUOT_W];
        end
    end

    assign o_quot_valid = r_v2;
    assign o_quot       = r_q;
endmodule

[design/pcns_search.sv]
// Binary search sequencer with one shared subtract/compare unit, one probe a cycle.
module pcns_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcns_pkg::QUOT_W-1:0]   i_quot,
    input  logic                          i_out_free,
    output pcns_pkg::t_search_stat        o_stat
);
    import pcns_pkg::*;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_lo, n_lo;
    logic [IDX_W-1:0]  r_hi, n_hi;
    logic [IDX_W-1:0]  r_best, n_best;
    logic [QUOT_W-1:0] r_best_diff, n_best_diff;
    logic              r_exact, n_exact;

    logic [IDX_W:0]    sum;
    logic [IDX_W-1:0]  mid;
    logic [IDX_W:0]    mid_inc;
    logic [IDX_W-1:0]  mid_dec;
    t_pll_row          row;
    logic [QUOT_W-1:0] f;
    logic [QUOT_W-1:0] diff;
    logic              f_gt;
    logic              f_eq;
    logic              done;

    // shared probe unit
    assign sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = sum[IDX_W:1];
    assign mid_inc = {1'b0, mid} + (IDX_W+1)'(1);
    assign mid_dec = mid - IDX_W'(1);
    assign row     = pll_rom_row(mid);
    assign f       = QUOT_W'(row.f10k);
    assign f_gt    = f > i_quot;
    assign f_eq    = f == i_quot;
    assign diff    = f_gt ? (f - i_quot) : (i_quot - f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_best      <= n_best;
        r_best_diff <= n_best_diff;
        r_exact     <= n_exact;
    end

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_best      = r_best;
        n_best_diff = r_best_diff;
        n_exact     = r_exact;
        done        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_lo        = '0;
                    n_hi        = LAST_IDX;
                    n_best      = '0;
                    n_best_diff = '1;
                    n_exact     = 1'b0;
                    n_state     = S_PROBE;
                end
            end
            S_PROBE: begin
                if (diff < r_best_diff) begin
                    n_best_diff = diff;
                    n_best      = mid;
                end
                priority if (f_eq) begin
                    n_best  = mid;
                    n_exact = 1'b1;
                    n_state = S_DONE;
                end else if (!f_gt) begin
                    n_lo = mid_inc[IDX_W-1:0];
                    if (mid_inc > {1'b0, r_hi}) begin
                        n_state = S_DONE;
                    end
                end else if (mid == '0) begin
                    // would step below the first entry: stop here
                    n_state = S_DONE;
                end else begin
                    n_hi = mid_dec;
                    if (r_lo > mid_dec) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stat.idle  = (r_state == S_IDLE);
    assign o_stat.done  = done;
    assign o_stat.idx   = r_best;
    assign o_stat.exact = r_exact;
endmodule

[design/pll_coefficient_nearest_search_core.sv]
// Top level: request channel, divider, search sequencer and result register.
//
// Usage: a request beat on i_in carries target_hz in hertz. The block truncates it to
// 10 kHz units and binary-searches the sorted PLL settings ROM, keeping the probed
// entry closest to the request and stopping early on an exact match. One result beat
// on o_out follows every request: entry index, frequency in hertz, M, N, K and the two
// packed PLL data bytes (N, then K<<6 | M).
// The request passes through the divider's registers, then the search probes the ROM
// entries one at a time through the shared compare unit, and a final state finishes
// the search and loads the result register.
// Throughput: one request at a time; i_in.ready drops at the request beat and rises
// again the cycle after the result is loaded, so a new request may be taken while the
// previous result still waits on o_out.
// Reset clears the sequencer, the valid flags and the busy flag; no result is pending.
// A stalled receiver holds the result in place; a finished search then waits until
// the result register is free.
module pll_coefficient_nearest_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcns_in_if.sink     i_in,
    pcns_out_if.source  o_out
);
    import pcns_pkg::*;

    logic              r_busy;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_idx;
    logic [ACT_W-1:0]  r_actual;
    logic [5:0]        r_m;
    logic [7:0]        r_n;
    logic [1:0]        r_k;
    logic              r_exact;

    logic              in_beat;
    logic              out_free;
    logic              quot_valid;
    logic [QUOT_W-1:0] quot;
    t_search_stat      stat;
    t_pll_row          res_row;
    logic [ACT_W-1:0]  n_actual;

    assign in_beat  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    pcns_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_beat),
        .i_target_hz  (i_in.target_hz),
        .o_quot_valid (quot_valid),
        .o_quot       (quot)
    );

    pcns_search u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (quot_valid),
        .i_quot     (quot),
        .i_out_free (out_free),
        .o_stat     (stat)
    );

    assign res_row  = pll_rom_row(stat.idx);
    assign n_actual = ACT_W'(res_row.f10k) * ACT_W'(HZ_PER_UNIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_busy <= 1'b1;
            end else if (stat.done) begin
                r_busy <= 1'b0;
            end
            if (stat.done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done) begin
            r_idx    <= stat.idx;
            r_actual <= n_actual;
            r_m      <= res_row.m;
            r_n      <= res_row.n;
            r_k      <= res_row.k;
            r_exact  <= stat.exact;
        end
    end

    assign i_in.ready        = !r_busy;
    assign o_out.valid       = r_out_valid;
    assign o_out.entry_index = r_idx;
    assign o_out.actual_hz   = r_actual;
    assign o_out.mult_m      = r_m;
    assign o_out.div_n       = r_n;
    assign o_out.post_k      = r_k;
    assign o_out.data_low    = r_n;
    assign o_out.data_high   = {r_k, r_m};
    assign o_out.exact_match = r_exact;

    // the sequencer only runs while a request is outstanding
    a_search_within_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !stat.idle |-> r_busy)
        else $error("search active without an outstanding request");

    // a request beat closes the input until its result is loaded
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !i_in.ready)
        else $error("input reopened right after a request beat");

    // the chosen entry lies within the searched part of the ROM
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_idx <= LAST_IDX))
        else $error("result entry index outside the searched table");
endmodule

[verif/pcns_result_checker.sv]
`timescale 1ns / 1ps
// Watches the request and result channels, predicts each PLL choice and compares it.
module pcns_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pcns_in_if   i_req,
    pcns_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_exact_hits
);
    import pcns_pkg::*;

    typedef struct packed {
        logic [5:0]  entry_index;
        logic [27:0] actual_hz;
        logic [5:0]  mult_m;
        logic [7:0]  div_n;
        logic [1:0]  post_k;
        logic [7:0]  data_low;
        logic [7:0]  data_high;
        logic        exact_match;
    } t_pll_choice;

    // PLL settings, ascending in frequency (10 kHz units), M, N, K
    t_pll_row    pll_settings [0:ROM_SIZE-1];
    t_pll_choice choice_q [$];
    t_pll_choice oldest;

    initial begin
        pll_settings = '{
            '{14'd1431,  6'd8,  8'd72,  2'd1}, '{14'd2506,  6'd2,  8'd27,  2'd1},
            '{14'd2520,  6'd23, 8'd168, 2'd1}, '{14'd2595,  6'd6,  8'd50,  2'd1},
            '{14'd2744,  6'd7,  8'd61,  2'd1}, '{14'd2828,  6'd8,  8'd71,  2'd1},
            '{14'd2833,  6'd21, 8'd174, 2'd1}, '{14'd2864,  6'd2,  8'd24,  2'd2},
            '{14'd3007,  6'd3,  8'd34,  2'd2}, '{14'd3150,  6'd8,  8'd80,  2'd2},
            '{14'd3257,  6'd8,  8'd83,  2'd2}, '{14'd3375,  6'd5,  8'd58,  2'd2},
            '{14'd3589,  6'd3,  8'd17,  2'd1}, '{14'd3759,  6'd6,  8'd34,  2'd1},
            '{14'd3848,  6'd6,  8'd35,  2'd1}, '{14'd4009,  6'd8,  8'd48,  2'd1},
            '{14'd4398,  6'd5,  8'd35,  2'd1}, '{14'd4474,  6'd6,  8'd42,  2'd1},
            '{14'd4725,  6'd3,  8'd25,  2'd1}, '{14'd5011,  6'd3,  8'd27,  2'd1},
            '{14'd5190,  6'd6,  8'd50,  2'd1}, '{14'd5489,  6'd7,  8'd61,  2'd1},
            '{14'd5656,  6'd8,  8'd71,  2'd1}, '{14'd5727,  6'd2,  8'd24,  2'd1},
            '{14'd6014,  6'd3,  8'd34,  2'd2}, '{14'd6300,  6'd8,  8'd80,  2'd1},
            '{14'd6515,  6'd8,  8'd83,  2'd1}, '{14'd6750,  6'd5,  8'd58,  2'd1},
            '{14'd7159,  6'd3,  8'd17,  2'd0}, '{14'd7517,  6'd6,  8'd34,  2'd0},
            '{14'd7696,  6'd6,  8'd35,  2'd0}, '{14'd8018,  6'd8,  8'd48,  2'd0},
            '{14'd8795,  6'd5,  8'd35,  2'd0}, '{14'd8949,  6'd6,  8'd42,  2'd0},
            '{14'd9450,  6'd3,  8'd25,  2'd0}, '{14'd10023, 6'd4,  8'd34,  2'd0},
            '{14'd10500, 6'd7,  8'd58,  2'd0}, '{14'd10818, 6'd7,  8'd60,  2'd0},
            '{14'd10977, 6'd7,  8'd61,  2'd0}, '{14'd11812, 6'd2,  8'd25,  2'd0},
            '{14'd12027, 6'd3,  8'd34,  2'd0}, '{14'd13091, 6'd5,  8'd56,  2'd0},
            '{14'd13500, 6'd7,  8'd58,  2'd0}
        };
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_exact_hits = 0;
    end

    // Binary search over the table, keeping the closest probe; the earlier probe wins
    // a tie, an exact hit stops the search, and stepping below row 0 ends it.
    function automatic t_pll_choice nearest_pll_setting(input logic [31:0] hz);
        logic [31:0] want_f10k;
        logic [31:0] row_f10k;
        logic [31:0] row_gap;
        logic [31:0] best_dist;
        logic [31:0] hz_out;
        int          lo;
        int          hi;
        int          mid;
        int          best;
        logic        exact;
        logic        searching;
        t_pll_row    row;
        t_pll_choice c;
        want_f10k = hz / 32'(HZ_PER_UNIT);
        lo        = 0;
        hi        = SEARCH_COUNT - 1;
        best      = 0;
        best_dist = 32'hFFFF_FFFF;
        exact     = 1'b0;
        searching = 1'b1;
        while (searching && lo <= hi) begin
            mid      = (lo + hi) / 2;
            row_f10k = 32'(pll_settings[mid].f10k);
            row_gap  = (row_f10k > want_f10k) ? row_f10k - want_f10k : want_f10k - row_f10k;
            if (row_gap < best_dist) begin
                best_dist = row_gap;
                best      = mid;
            end
            if (row_f10k == want_f10k) begin
                best      = mid;
                exact     = 1'b1;
                searching = 1'b0;
            end else if (row_f10k < want_f10k) begin
                lo = mid + 1;
            end else if (mid == 0) begin
                searching = 1'b0;
            end else begin
                hi = mid - 1;
            end
        end
        row           = pll_settings[best];
        hz_out        = 32'(row.f10k) * 32'(HZ_PER_UNIT);
        c.entry_index = 6'(best);
        c.actual_hz   = hz_out[27:0];
        c.mult_m      = row.m;
        c.div_n       = row.n;
        c.post_k      = row.k;
        c.data_low    = row.n;
        c.data_high   = {row.k, row.m};
        c.exact_match = exact;
        return c;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready)
                choice_q.push_back(nearest_pll_setting(i_req.target_hz));
            if (i_res.valid && i_res.ready) begin
                o_results++;
                if (choice_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual index %0d",
                             $time, i_res.entry_index);
                    o_fail_count++;
                end else begin
                    oldest = choice_q.pop_front();
                    if (oldest.exact_match)
                        o_exact_hits++;
                    compare_field("entry_index", 32'(oldest.entry_index), 32'(i_res.entry_index));
                    compare_field("actual_hz", 32'(oldest.actual_hz), 32'(i_res.actual_hz));
                    compare_field("mult_m", 32'(oldest.mult_m), 32'(i_res.mult_m));
                    compare_field("div_n", 32'(oldest.div_n), 32'(i_res.div_n));
                    compare_field("post_k", 32'(oldest.post_k), 32'(i_res.post_k));
                    compare_field("data_low", 32'(oldest.data_low), 32'(i_res.data_low));
                    compare_field("data_high", 32'(oldest.data_high), 32'(i_res.data_high));
                    compare_field("exact_match", 32'(oldest.exact_match),
                                  32'(i_res.exact_match));
                end
            end
            o_pending = choice_q.size();
        end
    end

endmodule

[verif/pll_coefficient_nearest_search_core_tb.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the PLL coefficient nearest-value search core.
module pll_coefficient_nearest_search_core_tb;
    import pcns_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEMS_PER_PASS = 100;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   sent_count = 0;
    int   cycle_count = 0;
    int   fail_count;
    int   pending;
    int   results;
    int   exact_hits;

    pcns_in_if  req_ch ();
    pcns_out_if res_ch ();

    pll_coefficient_nearest_search_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    pcns_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_exact_hits (exact_hits)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial res_ch.ready = 1'b0;

    always @(negedge clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_request(input logic [31:0] hz);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.target_hz <= hz;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Mostly requests landing on or near table rows, where the search does real work.
    function automatic logic [31:0] random_target();
        int          sel;
        int          idx;
        int          offs;
        t_pll_row    row_lo;
        t_pll_row    row_hi;
        logic [31:0] f_lo;
        logic [31:0] f_hi;
        sel    = $urandom_range(99);
        idx    = $urandom_range(ROM_SIZE - 1);
        row_lo = pll_rom_row(IDX_W'(idx));
        row_hi = pll_rom_row(IDX_W'((idx < ROM_SIZE - 1) ? idx + 1 : idx));
        f_lo   = 32'(row_lo.f10k);
        f_hi   = 32'(row_hi.f10k);
        if (sel < 35) begin
            return f_lo * 32'(HZ_PER_UNIT) + 32'($urandom_range(HZ_PER_UNIT - 1));
        end else if (sel < 60) begin
            offs = $urandom_range(16);
            return (f_lo + 32'(offs) - 32'd8) * 32'(HZ_PER_UNIT)
                   + 32'($urandom_range(HZ_PER_UNIT - 1));
        end else if (sel < 72) begin
            // halfway between neighbors, rounded either way, to hit distance ties
            return ((f_lo + f_hi + 32'($urandom_range(1))) / 2) * 32'(HZ_PER_UNIT)
                   + 32'($urandom_range(HZ_PER_UNIT - 1));
        end else if (sel < 86) begin
            return 32'($urandom_range(150_000_000));
        end else begin
            return $urandom();
        end
    endfunction

    initial begin
        logic [31:0] directed [$];
        int          pass_no;
        req_ch.valid     = 1'b0;
        req_ch.target_hz = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // field extremes, table ends, the bottom stop, a tie and a mid-table exact hit
        directed = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd9999, 32'd10000, 32'd14_299_999,
                     32'd14_309_999, 32'd14_310_000, 32'd14_319_999, 32'd25_130_000,
                     32'd28_305_000, 32'd54_890_000, 32'd134_999_999, 32'd135_000_000,
                     32'd135_009_999, 32'd200_000_000, 32'h8000_0000, 32'h5555_5555,
                     32'hAAAA_AAAA};
        foreach (directed[i])
            send_request(directed[i]);
        drain_results();

        for (pass_no = 0; pass_no < 4; pass_no++) begin
            case (pass_no)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            repeat (ITEMS_PER_PASS)
                send_request(random_target());
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (20) @(negedge clk);
        $display("Sent %0d frequency requests (directed edges, then four idle/stall passes);",
                 sent_count);
        $display("checked %0d PLL results, %0d of them exact 10 kHz hits.", results, exact_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
